FILE: sv/mbb_pkg.sv
// Package for the 1-bit bitmap blitter: command codes, sequencer states,
// configuration register indexes and the mode group sent to the word unit.
// No dependencies.
`default_nettype none

package mbb_pkg;

    localparam int SRC_BITS = 64;

    typedef enum logic [2:0] {
        REQ_READ  = 3'd0,
        REQ_WRITE = 3'd1,
        REQ_CLEAR = 3'd2,
        REQ_FILL  = 3'd3,
        REQ_BLIT  = 3'd4
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SETUP,
        ST_ADDR,
        ST_READ,
        ST_MODIFY,
        ST_FINISH
    } state_t;

    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [8:0] SIZE_RESET = 9'd256;

    typedef struct packed {
        logic blit;
        logic merge;
        logic color;
    } word_mode_t;

endpackage

`default_nettype wire

FILE: sv/mbb_if.sv
// Valid/ready channel interfaces for the blitter's request and result sides.
// Stand-alone; no package needed.
`default_nettype none

interface mbb_cmd_if;
    logic              valid;
    logic              ready;
    logic [2:0]        req_type;
    logic signed [8:0] x_start;
    logic signed [8:0] y_start;
    logic [7:0]        x_end;
    logic [7:0]        y_end;
    logic              color;
    logic [63:0]       src_row;
    logic [6:0]        src_width;
    logic              merge_mode;

    modport source (
        output valid, req_type, x_start, y_start, x_end, y_end, color,
               src_row, src_width, merge_mode,
        input  ready
    );

    modport sink (
        input  valid, req_type, x_start, y_start, x_end, y_end, color,
               src_row, src_width, merge_mode,
        output ready
    );
endinterface

interface mbb_rsp_if;
    logic valid;
    logic ready;
    logic pixel;

    modport source (
        output valid, pixel,
        input  ready
    );

    modport sink (
        input  valid, pixel,
        output ready
    );
endinterface

`default_nettype wire

FILE: sv/mbb_word_unit.sv
// Read-modify-write datapath for one bitmap word: column mask, shifted blit
// source, merged write word and single pixel extraction. Uses mbb_pkg.
`default_nettype none

module mbb_word_unit #(
    parameter int WORD_BITS = 64,
    parameter int XW        = 8
) (
    input  mbb_pkg::word_mode_t   mode,
    input  logic [WORD_BITS-1:0]  rd_word,
    input  logic [XW-1:0]         base,
    input  logic [XW-1:0]         lo,
    input  logic [XW-1:0]         hi,
    input  logic signed [8:0]     x_start,
    input  logic [63:0]           src_row,
    output logic [WORD_BITS-1:0]  wr_word,
    output logic                  rd_pixel,
    output logic                  last_word
);
    import mbb_pkg::*;

    localparam int OW  = $clog2(WORD_BITS);
    localparam int DW  = ((XW > 9) ? XW : 9) + 2;
    localparam int SHW = $clog2(SRC_BITS);

    logic signed [XW:0]    lo_diff;
    logic [XW:0]           hi_diff;
    logic [OW-1:0]         lo_off;
    logic [OW-1:0]         hi_off;
    logic [WORD_BITS-1:0]  mask;
    logic signed [DW-1:0]  d;
    logic signed [DW-1:0]  neg_d;
    logic [SRC_BITS-1:0]   shifted;
    logic [WORD_BITS-1:0]  src_word;
    logic [WORD_BITS-1:0]  new_bits;

    // Offsets of the clipped column range relative to this word's first pixel.
    assign lo_diff   = $signed({1'b0, lo}) - $signed({1'b0, base});
    assign hi_diff   = {1'b0, hi} - {1'b0, base};
    assign last_word = hi_diff < (XW+1)'(WORD_BITS);
    assign lo_off    = lo_diff[XW] ? '0 : lo_diff[OW-1:0];
    assign hi_off    = last_word ? hi_diff[OW-1:0] : OW'(WORD_BITS - 1);
    assign mask      = ({WORD_BITS{1'b1}} << lo_off)
                     & ({WORD_BITS{1'b1}} >> (OW'(WORD_BITS - 1) - hi_off));

    // Bit b of this word takes source pixel (base - x_start + b).
    assign d     = DW'({1'b0, base}) - DW'(x_start);
    assign neg_d = -d;

    always_comb
    begin
        if (d[DW-1])
        begin
            shifted = src_row << neg_d[SHW-1:0];
        end
        else if (d >= DW'(SRC_BITS))
        begin
            shifted = '0;
        end
        else
        begin
            shifted = src_row >> d[SHW-1:0];
        end
    end

    assign src_word = shifted[WORD_BITS-1:0];
    assign new_bits = mode.blit ? src_word : {WORD_BITS{mode.color}};
    assign wr_word  = (mode.blit && mode.merge) ? (rd_word | (src_word & mask))
                                                : ((rd_word & ~mask) | (new_bits & mask));
    assign rd_pixel = rd_word[lo_off];

endmodule

`default_nettype wire

FILE: sv/mono_bitmap_blitter.sv
// Pixel read or write: SETUP, ADDR, READ and MODIFY, then FINISH loads the result register.
// Fill rectangle: READ and MODIFY per touched word per row. Row blit: the same per touched word (1 or 2 words).
// Clear all: one word per cycle over the whole store.
// Each fill, blit or pixel-write word costs a read and a write on the single memory port. One request at
// a time; the result register lets the next request in while a result waits.
// Reset sets both size registers to 256; bitmap contents stay undefined.
`default_nettype none

module mono_bitmap_blitter #(
    parameter int MAX_WIDTH     = 256,
    parameter int MAX_HEIGHT    = 256,
    parameter int ROW_WORD_BITS = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_index,
    input  wire logic [8:0] cfg_wdata,
    mbb_cmd_if.sink         cmd,
    mbb_rsp_if.source       rsp
);
    import mbb_pkg::*;

    localparam int WPR         = (MAX_WIDTH + ROW_WORD_BITS - 1) / ROW_WORD_BITS;
    localparam int STORE_DEPTH = WPR * MAX_HEIGHT;
    localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int XW          = $clog2(MAX_WIDTH);
    localparam int YW          = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int QW          = (WPR > 1) ? $clog2(WPR) : 1;
    localparam int MAXDIM      = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int CW          = $clog2(MAXDIM + 512) + 1;
    // Column to word index by a reciprocal multiply, exact for all XW-bit columns.
    localparam int DS          = XW + $clog2(ROW_WORD_BITS) + 1;
    localparam int DM          = (2**DS + ROW_WORD_BITS - 1) / ROW_WORD_BITS;
    localparam int DMW         = $clog2(DM + 1);
    localparam int PW          = XW + DMW;
    localparam int BW          = XW + 7;

    localparam logic signed [CW-1:0] C_ZERO = '0;
    localparam logic signed [CW-1:0] C_ONE  = CW'(1);

    state_t state_reg, state_next;
    logic [8:0] width_reg, width_next;
    logic [8:0] height_reg, height_next;
    logic       rsp_valid_reg, rsp_valid_next;

    req_t                 op_reg, op_next;
    logic [XW-1:0]        lo_reg, lo_next;
    logic [XW-1:0]        hi_reg, hi_next;
    logic [YW-1:0]        y_cur_reg, y_cur_next;
    logic [YW-1:0]        y_last_reg, y_last_next;
    logic                 color_reg, color_next;
    logic                 merge_reg, merge_next;
    logic signed [8:0]    xs_reg, xs_next;
    logic [63:0]          src_reg, src_next;
    logic [QW-1:0]        q_reg, q_next;
    logic [XW-1:0]        base0_reg, base0_next;
    logic [XW-1:0]        base_reg, base_next;
    logic [AW-1:0]        rowbase_reg, rowbase_next;
    logic [AW-1:0]        addr_reg, addr_next;
    logic                 result_pix_reg, result_pix_next;
    logic                 pixel_reg, pixel_next;
    logic [ROW_WORD_BITS-1:0] rd_word_reg;

    logic [ROW_WORD_BITS-1:0] mem [STORE_DEPTH];

    logic                     mem_we;
    logic [ROW_WORD_BITS-1:0] mem_wdata;
    logic [ROW_WORD_BITS-1:0] wr_word;
    logic                     rd_pixel;
    logic                     last_word;
    logic                     rsp_load;
    word_mode_t               mode;

    logic signed [CW-1:0] eff_w, eff_h;
    logic signed [CW-1:0] xs_c, ys_c, xe_c, ye_c, sw_c;
    logic signed [CW-1:0] lo_c, hi_c, ya_c, yb_c;
    logic [6:0]           sw_clamp;
    logic                 empty_c;
    logic [PW-1:0]        div_prod;

    always_comb
    begin
        eff_w = ({{(CW-9){1'b0}}, width_reg} > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH)
              : {{(CW-9){1'b0}}, width_reg};
        eff_h = ({{(CW-9){1'b0}}, height_reg} > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT)
              : {{(CW-9){1'b0}}, height_reg};
    end

    // Clip the request against the configured size when it is taken.
    always_comb
    begin
        xs_c     = CW'(cmd.x_start);
        ys_c     = CW'(cmd.y_start);
        xe_c     = {{(CW-8){1'b0}}, cmd.x_end};
        ye_c     = {{(CW-8){1'b0}}, cmd.y_end};
        sw_clamp = (cmd.src_width > 7'd64) ? 7'd64 : cmd.src_width;
        sw_c     = {{(CW-7){1'b0}}, sw_clamp};
        lo_c     = xs_c;
        hi_c     = xs_c;
        ya_c     = ys_c;
        yb_c     = ys_c;
        empty_c  = 1'b1;
        unique case (cmd.req_type)
            REQ_READ, REQ_WRITE:
            begin
                empty_c = !(xs_c >= C_ZERO && ys_c >= C_ZERO && xs_c < eff_w
                            && ys_c < eff_h);
            end
            REQ_FILL:
            begin
                lo_c    = (xs_c < C_ZERO) ? C_ZERO : xs_c;
                hi_c    = (xe_c < eff_w - C_ONE) ? xe_c : eff_w - C_ONE;
                ya_c    = (ys_c < C_ZERO) ? C_ZERO : ys_c;
                yb_c    = (ye_c < eff_h - C_ONE) ? ye_c : eff_h - C_ONE;
                empty_c = (lo_c > hi_c) || (ya_c > yb_c);
            end
            REQ_BLIT:
            begin
                lo_c    = (xs_c < C_ZERO) ? C_ZERO : xs_c;
                hi_c    = (xs_c + sw_c - C_ONE < eff_w - C_ONE) ? xs_c + sw_c - C_ONE
                        : eff_w - C_ONE;
                empty_c = (ys_c < C_ZERO) || (ys_c >= eff_h) || (sw_clamp == 7'd0)
                       || (lo_c > hi_c);
            end
            REQ_CLEAR:
            begin
                empty_c = 1'b0;
            end
            default:
            begin
                empty_c = 1'b1;
            end
        endcase
    end

    assign div_prod = PW'(lo_reg) * PW'(DM);

    assign mode.blit  = (op_reg == REQ_BLIT);
    assign mode.merge = merge_reg;
    assign mode.color = color_reg;

    mbb_word_unit #(
        .WORD_BITS (ROW_WORD_BITS),
        .XW        (XW)
    ) u_word (
        .mode      (mode),
        .rd_word   (rd_word_reg),
        .base      (base_reg),
        .lo        (lo_reg),
        .hi        (hi_reg),
        .x_start   (xs_reg),
        .src_row   (src_reg),
        .wr_word   (wr_word),
        .rd_pixel  (rd_pixel),
        .last_word (last_word)
    );

    assign cmd.ready = (state_reg == ST_IDLE);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.pixel = pixel_reg;

    // Sequencer: next state, loop counters and memory control.
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        y_cur_next      = y_cur_reg;
        y_last_next     = y_last_reg;
        color_next      = color_reg;
        merge_next      = merge_reg;
        xs_next         = xs_reg;
        src_next        = src_reg;
        q_next          = q_reg;
        base0_next      = base0_reg;
        base_next       = base_reg;
        rowbase_next    = rowbase_reg;
        addr_next       = addr_reg;
        result_pix_next = result_pix_reg;
        mem_we          = 1'b0;
        mem_wdata       = wr_word;
        rsp_load        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next         = req_t'(cmd.req_type);
                    lo_next         = XW'(lo_c);
                    hi_next         = XW'(hi_c);
                    y_cur_next      = YW'(ya_c);
                    y_last_next     = YW'(yb_c);
                    color_next      = cmd.color;
                    merge_next      = cmd.merge_mode;
                    xs_next         = cmd.x_start;
                    src_next        = cmd.src_row;
                    result_pix_next = 1'b0;
                    addr_next       = '0;
                    if (empty_c)
                    begin
                        state_next = ST_FINISH;
                    end
                    else if (cmd.req_type == REQ_CLEAR)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = {ROW_WORD_BITS{color_reg}};
                if (addr_reg == AW'(STORE_DEPTH - 1))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    addr_next = addr_reg + AW'(1);
                end
            end
            ST_SETUP:
            begin
                q_next       = QW'(div_prod >> DS);
                rowbase_next = AW'(AW'(y_cur_reg) * AW'(WPR));
                state_next   = ST_ADDR;
            end
            ST_ADDR:
            begin
                base0_next = XW'(BW'(q_reg) * BW'(ROW_WORD_BITS));
                base_next  = XW'(BW'(q_reg) * BW'(ROW_WORD_BITS));
                addr_next  = rowbase_reg + AW'(q_reg);
                state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_MODIFY;
            end
            ST_MODIFY:
            begin
                if (op_reg == REQ_READ)
                begin
                    result_pix_next = rd_pixel;
                end
                else
                begin
                    mem_we = 1'b1;
                end
                if (!last_word)
                begin
                    base_next  = XW'(BW'(base_reg) + BW'(ROW_WORD_BITS));
                    addr_next  = addr_reg + AW'(1);
                    state_next = ST_READ;
                end
                else if (y_cur_reg != y_last_reg)
                begin
                    y_cur_next   = y_cur_reg + YW'(1);
                    rowbase_next = rowbase_reg + AW'(WPR);
                    addr_next    = rowbase_reg + AW'(WPR) + AW'(q_reg);
                    base_next    = base0_reg;
                    state_next   = ST_READ;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  width_next  = cfg_wdata;
                CFG_IMAGE_HEIGHT: height_next = cfg_wdata;
                default:          width_next  = width_reg;
            endcase
        end
    end

    assign rsp_valid_next = rsp_load ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_reg);
    assign pixel_next     = rsp_load ? result_pix_reg : pixel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            width_reg     <= SIZE_RESET;
            height_reg    <= SIZE_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        y_cur_reg      <= y_cur_next;
        y_last_reg     <= y_last_next;
        color_reg      <= color_next;
        merge_reg      <= merge_next;
        xs_reg         <= xs_next;
        src_reg        <= src_next;
        q_reg          <= q_next;
        base0_reg      <= base0_next;
        base_reg       <= base_next;
        rowbase_reg    <= rowbase_next;
        addr_reg       <= addr_next;
        result_pix_reg <= result_pix_next;
        pixel_reg      <= pixel_next;
    end

    // Single-port bitmap store with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr_reg] <= mem_wdata;
        end
        rd_word_reg <= mem[addr_reg];
    end

    // The word being modified always starts at or left of the last column.
    a_word_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MODIFY |-> base_reg <= hi_reg)
        else $error("word base beyond clipped column range");

    // The row walk never passes the last clipped row.
    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MODIFY |-> y_cur_reg <= y_last_reg)
        else $error("row counter beyond last row");

    // A taken request closes the input until its work is done.
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready |=> !cmd.ready)
        else $error("request accepted while busy");

    // A finished result never overwrites one still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FINISH && rsp_valid_reg && !rsp.ready
        |=> rsp_valid_reg && $stable(pixel_reg))
        else $error("pending result overwritten");

endmodule

`default_nettype wire
